### src/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic REG_MAX_PAYLOAD = 1'b0;

  localparam logic [31:0] MAX_PAYLOAD_RST = 32'd65535;

  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES    = 4'd2;
  localparam logic [3:0] EXT64_BYTES    = 4'd8;
  localparam logic [3:0] MASK_KEY_BYTES = 4'd4;

  typedef enum logic [4:0] {
    PH_HDR0 = 5'b00001,
    PH_HDR1 = 5'b00010,
    PH_EXT  = 5'b00100,
    PH_KEY  = 5'b01000,
    PH_DATA = 5'b10000
  } wsd_phase_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_data;
    logic       frame_last;
    logic       fin_flag;
    logic [3:0] frame_opcode;
    logic       mask_flag;
    logic       status;
  } wsd_result_t;

endpackage

### src/wsd_in_if.sv
// ----------------------------------------------------------------------------
// wsd_in_if
// Receive byte channel with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### src/wsd_out_if.sv
// ----------------------------------------------------------------------------
// wsd_out_if
// Result channel of the deframer with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface wsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       has_data;
  logic       frame_last;
  logic       fin_flag;
  logic [3:0] frame_opcode;
  logic       mask_flag;
  logic       status;

  modport source (
    output valid, output payload_byte, output has_data, output frame_last,
    output fin_flag, output frame_opcode, output mask_flag, output status,
    input ready
  );
  modport sink (
    input valid, input payload_byte, input has_data, input frame_last,
    input fin_flag, input frame_opcode, input mask_flag, input status,
    output ready
  );
endinterface

### src/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket frame parser with an APB configuration port.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle unless the output stalls,
// and gives at most one result item per byte, in the cycle after the byte is
// accepted. Each byte is handled by the combinational header and length
// logic, which feeds a one-entry output register; the input stays ready
// while that register is empty or is being read, so a full byte per clock
// is sustained when the sink keeps its ready high. Payloads are passed
// through still masked, oversized frames give one error item and their
// payload is dropped, and the max_payload register sits at byte address 0.
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  wsd_in_if.sink                in_ch,
  wsd_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [31:0] max_payload_r;
  wsd_result_t result;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_MAX_PAYLOAD) ? max_payload_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_wr && (paddr[2] == REG_MAX_PAYLOAD)) begin
      max_payload_r <= pwdata;
    end
  end

  wsd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .max_payload (max_payload_r),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .rx_byte     (in_ch.rx_byte),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_result  (result)
  );

  assign out_ch.payload_byte = result.payload_byte;
  assign out_ch.has_data     = result.has_data;
  assign out_ch.frame_last   = result.frame_last;
  assign out_ch.fin_flag     = result.fin_flag;
  assign out_ch.frame_opcode = result.frame_opcode;
  assign out_ch.mask_flag    = result.mask_flag;
  assign out_ch.status       = result.status;

endmodule

### src/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header parser and payload pass-through with a registered result.
// ----------------------------------------------------------------------------
module wsd_parser
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] max_payload,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output wsd_result_t out_result
);

  wsd_phase_t  phase_r, phase_nxt;
  logic [3:0]  ext_left_r, ext_left_nxt;
  logic [63:0] len_r, len_nxt;
  logic        skip_r, skip_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        mask_r, mask_nxt;
  logic        out_valid_r, out_valid_nxt;
  wsd_result_t res_r;

  wsd_result_t res;
  logic        res_valid;
  logic        accept;
  logic        len_end;
  logic        hdr_done;
  logic [63:0] end_len;
  logic [63:0] len_shift;
  logic [3:0]  ext_dec;
  logic        too_long;
  logic        data_last;

  assign in_ready   = !out_valid_r || out_ready;
  assign accept     = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_result = res_r;

  assign len_shift = {len_r[55:0], rx_byte};
  assign ext_dec   = (ext_left_r != 4'd0) ? ext_left_r - 4'd1 : 4'd0;
  assign data_last = (len_r[63:1] == 63'd0);
  assign too_long  = (end_len[63:32] != 32'd0) || (end_len[31:0] > max_payload);

  always_comb begin
    phase_nxt    = phase_r;
    ext_left_nxt = ext_left_r;
    len_nxt      = len_r;
    skip_nxt     = skip_r;
    fin_nxt      = fin_r;
    opcode_nxt   = opcode_r;
    mask_nxt     = mask_r;
    len_end      = 1'b0;
    hdr_done     = 1'b0;
    end_len      = len_r;
    res_valid    = 1'b0;
    res          = '0;

    case (phase_r)
      PH_HDR1: begin
        mask_nxt = rx_byte[7];
        len_nxt  = 64'd0;
        if (rx_byte[6:0] == LEN_CODE_EXT16) begin
          ext_left_nxt = EXT16_BYTES;
          phase_nxt    = PH_EXT;
        end else if (rx_byte[6:0] == LEN_CODE_EXT64) begin
          ext_left_nxt = EXT64_BYTES;
          phase_nxt    = PH_EXT;
        end else begin
          len_nxt = {57'd0, rx_byte[6:0]};
          end_len = {57'd0, rx_byte[6:0]};
          len_end = 1'b1;
        end
      end
      PH_EXT: begin
        len_nxt      = len_shift;
        end_len      = len_shift;
        ext_left_nxt = ext_dec;
        len_end      = (ext_dec == 4'd0);
      end
      PH_KEY: begin
        ext_left_nxt = ext_dec;
        hdr_done     = (ext_dec == 4'd0);
      end
      PH_DATA: begin
        len_nxt = (len_r != 64'd0) ? len_r - 64'd1 : 64'd0;
        if (data_last) begin
          phase_nxt = PH_HDR0;
        end
        if (skip_r) begin
          if (data_last) begin
            skip_nxt = 1'b0;
          end
        end else begin
          res_valid        = 1'b1;
          res.payload_byte = rx_byte;
          res.has_data     = 1'b1;
          res.frame_last   = data_last;
        end
      end
      default: begin
        fin_nxt      = rx_byte[7];
        opcode_nxt   = rx_byte[3:0];
        mask_nxt     = 1'b0;
        skip_nxt     = 1'b0;
        ext_left_nxt = 4'd0;
        len_nxt      = 64'd0;
        phase_nxt    = PH_HDR1;
      end
    endcase

    if (len_end) begin
      if (mask_nxt) begin
        ext_left_nxt = MASK_KEY_BYTES;
        phase_nxt    = PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      if (too_long) begin
        res_valid      = 1'b1;
        res.frame_last = 1'b1;
        res.status     = 1'b1;
        skip_nxt       = 1'b1;
        phase_nxt      = PH_DATA;
      end else if (end_len == 64'd0) begin
        res_valid      = 1'b1;
        res.frame_last = 1'b1;
        phase_nxt      = PH_HDR0;
      end else begin
        skip_nxt  = 1'b0;
        phase_nxt = PH_DATA;
      end
    end

    res.fin_flag     = fin_nxt;
    res.frame_opcode = opcode_nxt;
    res.mask_flag    = mask_nxt;
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = res_valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      ext_left_r  <= 4'd0;
      len_r       <= 64'd0;
      skip_r      <= 1'b0;
      fin_r       <= 1'b0;
      opcode_r    <= 4'd0;
      mask_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        phase_r    <= phase_nxt;
        ext_left_r <= ext_left_nxt;
        len_r      <= len_nxt;
        skip_r     <= skip_nxt;
        fin_r      <= fin_nxt;
        opcode_r   <= opcode_nxt;
        mask_r     <= mask_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      res_r <= res;
    end
  end

endmodule
